### rtl/frame_capture_record_ring_defines.svh
// Assertion helpers for the capture ring RTL.
`ifndef FRAME_CAPTURE_RECORD_RING_DEFINES_SVH
`define FRAME_CAPTURE_RECORD_RING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/fcrr_pkg.sv
`timescale 1ns / 1ps

package fcrr_pkg;

	localparam int RING_BYTES_DEFAULT = 8192;
	localparam int HDR_BYTES          = 16;
	localparam int MS_PER_SEC         = 1000;
	localparam int USEC_PER_MS        = 1000;
	localparam int CMD_DEPTH          = 2;
	localparam int RES_DEPTH          = 2;

	// Header divide: four quotient bits per cycle over a 32-bit timestamp
	localparam int DIV_DIGIT_W = 4;
	localparam int DIV_STEPS   = 32 / DIV_DIGIT_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_EN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SNAP_LEN   = 1'd1;

	localparam logic [11:0] SNAP_LEN_RESET = 12'd512;

	localparam logic [1:0] ACT_FRAME_START = 2'd0;
	localparam logic [1:0] ACT_FRAME_DATA  = 2'd1;
	localparam logic [1:0] ACT_READ        = 2'd2;

	localparam logic [1:0] FT_MGMT = 2'd0;
	localparam logic [1:0] FT_DATA = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_HDR,
		OP_BYTE,
		OP_READ
	} cmd_op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_MUL,
		BK_HDR,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  frame_type;
		logic [11:0] frame_length;
		logic [31:0] time_ms;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        read_valid;
		logic        frame_accepted;
		logic [12:0] fill_bytes;
		logic [31:0] packets_seen;
		logic [31:0] frames_dropped;
	} result_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [31:0] time_ms;
		logic [11:0] stored_len;
		logic [11:0] frame_length;
		logic [7:0]  data_byte;
		logic        accepted;
		logic [12:0] fill_bytes;
		logic [31:0] packets_seen;
		logic [31:0] frames_dropped;
	} cmd_t;

endpackage

### rtl/fcrr_fifo.sv
`timescale 1ns / 1ps

module fcrr_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t din,
	input  logic  pop,
	output logic  empty,
	output item_t dout
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic  [AW-1:0] wr_q;
	logic  [AW-1:0] rd_q;
	logic  [CW-1:0] cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

### rtl/fcrr_front.sv
`timescale 1ns / 1ps

module fcrr_front #(
	parameter int RING_BYTES = fcrr_pkg::RING_BYTES_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fcrr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fcrr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             push,
	output logic                             full,
	input  fcrr_pkg::in_item_t               item,
	output logic                             cmd_push,
	input  logic                             cmd_full,
	output fcrr_pkg::cmd_t                   cmd
);

	localparam int PTR_W = $clog2(RING_BYTES);
	localparam int SUM_W = ((PTR_W > 13) ? PTR_W : 13) + 1;

	logic              cap_en_q;
	logic [11:0]       snap_q;
	logic [PTR_W-1:0]  fill_q;
	logic [11:0]       pend_q;
	logic [31:0]       seen_q;
	logic [31:0]       drop_q;

	logic              accept;
	logic              match;
	logic              fits;
	logic [11:0]       incl;
	logic [SUM_W-1:0]  need;
	logic [PTR_W-1:0]  fill_n;
	logic [11:0]       pend_n;
	logic [31:0]       seen_n;
	logic [31:0]       drop_n;
	fcrr_pkg::cmd_op_t op;
	logic              accepted;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full;
	assign accept    = push && !full;
	assign cmd_push  = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_q <= 1'b0;
			snap_q   <= fcrr_pkg::SNAP_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fcrr_pkg::CFG_CAPTURE_EN: cap_en_q <= cfg_data[0];
				fcrr_pkg::CFG_SNAP_LEN:   snap_q   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// Classify the item and update ring fill and counts up front
	always_comb begin
		incl     = (item.frame_length < snap_q) ? item.frame_length : snap_q;
		need     = SUM_W'(fcrr_pkg::HDR_BYTES) + SUM_W'(incl);
		fits     = (need + SUM_W'(fill_q)) <= SUM_W'(RING_BYTES - 1);
		match    = cap_en_q && (item.frame_type inside {fcrr_pkg::FT_MGMT, fcrr_pkg::FT_DATA});
		fill_n   = fill_q;
		pend_n   = pend_q;
		seen_n   = seen_q;
		drop_n   = drop_q;
		op       = fcrr_pkg::OP_NONE;
		accepted = 1'b0;
		case (item.action)
			fcrr_pkg::ACT_FRAME_START: begin
				pend_n = '0;
				if (match) begin
					seen_n = seen_q + 32'd1;
					if (fits) begin
						op       = fcrr_pkg::OP_HDR;
						accepted = 1'b1;
						pend_n   = incl;
						fill_n   = fill_q + PTR_W'(fcrr_pkg::HDR_BYTES);
					end else begin
						drop_n = drop_q + 32'd1;
					end
				end
			end
			fcrr_pkg::ACT_FRAME_DATA: begin
				if (pend_q != '0) begin
					op     = fcrr_pkg::OP_BYTE;
					pend_n = pend_q - 12'd1;
					fill_n = fill_q + 1'b1;
				end
			end
			fcrr_pkg::ACT_READ: begin
				if (fill_q != '0) begin
					op     = fcrr_pkg::OP_READ;
					fill_n = fill_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pend_q <= '0;
			seen_q <= '0;
			drop_q <= '0;
		end else if (accept) begin
			fill_q <= fill_n;
			pend_q <= pend_n;
			seen_q <= seen_n;
			drop_q <= drop_n;
		end
	end

	always_comb begin
		cmd.op             = op;
		cmd.time_ms        = item.time_ms;
		cmd.stored_len     = incl;
		cmd.frame_length   = item.frame_length;
		cmd.data_byte      = item.data_byte;
		cmd.accepted       = accepted;
		cmd.fill_bytes     = 13'(fill_n);
		cmd.packets_seen   = seen_n;
		cmd.frames_dropped = drop_n;
	end

endmodule

### rtl/fcrr_back.sv
`timescale 1ns / 1ps

module fcrr_back #(
	parameter int RING_BYTES = fcrr_pkg::RING_BYTES_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fcrr_pkg::cmd_t    cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output fcrr_pkg::result_t res,
	output logic              res_push,
	input  logic              res_full
);

	localparam int PTR_W = $clog2(RING_BYTES);
	localparam int DW    = fcrr_pkg::DIV_DIGIT_W;

	fcrr_pkg::back_state_t state_q;
	fcrr_pkg::back_state_t state_n;

	logic [7:0]       ring_q [RING_BYTES];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [2:0]       cnt_q;
	logic [3:0]       idx_q;

	fcrr_pkg::cmd_t   cmd_q;
	logic [31:0]      dq_q;
	logic [9:0]       rem_q;
	logic [19:0]      usec_q;
	logic [7:0]       rd_data_q;

	logic             mem_we;
	logic             mem_re;
	logic [7:0]       mem_wdata;
	logic [31:0]      hdr_word;
	logic [31:0]      hdr_shift;
	logic [7:0]       hdr_byte;
	logic [10:0]      r;
	logic [DW-1:0]    qb;
	logic [9:0]       rem_n;
	logic [31:0]      dq_n;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + 1'b1;
	endfunction

	// One radix-16 restoring step of the timestamp divide by 1000
	always_comb begin
		r  = {1'b0, rem_q};
		qb = '0;
		for (int i = 0; i < DW; i++) begin
			r = {r[9:0], dq_q[31 - i]};
			if (r >= 11'(fcrr_pkg::MS_PER_SEC)) begin
				r             = r - 11'(fcrr_pkg::MS_PER_SEC);
				qb[DW - 1 - i] = 1'b1;
			end
		end
		rem_n = r[9:0];
		dq_n  = {dq_q[31-DW:0], qb};
	end

	always_comb begin
		case (idx_q[3:2])
			2'd0:    hdr_word = dq_q;
			2'd1:    hdr_word = 32'(usec_q);
			2'd2:    hdr_word = 32'(cmd_q.stored_len);
			default: hdr_word = 32'(cmd_q.frame_length);
		endcase
		hdr_shift = hdr_word >> {idx_q[1:0], 3'b000};
		hdr_byte  = hdr_shift[7:0];
	end

	always_comb begin
		state_n   = state_q;
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		res_push  = 1'b0;
		mem_wdata = (state_q == fcrr_pkg::BK_HDR) ? hdr_byte : cmd.data_byte;
		case (state_q)
			fcrr_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					state_n = fcrr_pkg::BK_DONE;
					case (cmd.op)
						fcrr_pkg::OP_HDR:  state_n = fcrr_pkg::BK_DIV;
						fcrr_pkg::OP_BYTE: mem_we  = 1'b1;
						fcrr_pkg::OP_READ: mem_re  = 1'b1;
						default: ;
					endcase
				end
			end
			fcrr_pkg::BK_DIV: begin
				if (cnt_q == 3'(fcrr_pkg::DIV_STEPS - 1)) begin
					state_n = fcrr_pkg::BK_MUL;
				end
			end
			fcrr_pkg::BK_MUL: state_n = fcrr_pkg::BK_HDR;
			fcrr_pkg::BK_HDR: begin
				mem_we = 1'b1;
				if (idx_q == 4'(fcrr_pkg::HDR_BYTES - 1)) begin
					state_n = fcrr_pkg::BK_DONE;
				end
			end
			fcrr_pkg::BK_DONE: begin
				// hold the result until the output queue has room
				if (!res_full) begin
					res_push = 1'b1;
					state_n  = fcrr_pkg::BK_IDLE;
				end
			end
			default: state_n = fcrr_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcrr_pkg::BK_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			if (mem_we) begin
				wp_q <= ptr_inc(wp_q);
			end
			if (mem_re) begin
				rp_q <= ptr_inc(rp_q);
			end
			if (state_q == fcrr_pkg::BK_IDLE) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				if (state_q == fcrr_pkg::BK_DIV) begin
					cnt_q <= cnt_q + 3'd1;
				end
				if (state_q == fcrr_pkg::BK_HDR) begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
			dq_q  <= cmd.time_ms;
			rem_q <= '0;
		end else if (state_q == fcrr_pkg::BK_DIV) begin
			dq_q  <= dq_n;
			rem_q <= rem_n;
		end
		if (state_q == fcrr_pkg::BK_MUL) begin
			usec_q <= 20'(rem_q) * 20'(fcrr_pkg::USEC_PER_MS);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_q[wp_q] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= ring_q[rp_q];
		end
	end

	always_comb begin
		res.read_data      = (cmd_q.op == fcrr_pkg::OP_READ) ? rd_data_q : 8'd0;
		res.read_valid     = (cmd_q.op == fcrr_pkg::OP_READ);
		res.frame_accepted = cmd_q.accepted;
		res.fill_bytes     = cmd_q.fill_bytes;
		res.packets_seen   = cmd_q.packets_seen;
		res.frames_dropped = cmd_q.frames_dropped;
	end

endmodule

### rtl/frame_capture_record_ring.sv
// Items pass from the front end through the command queue and the back-end sequencer to the
// result queue; a recorded frame start also passes a divide, 1 multiply and 16 header byte writes.
// The back-end sequencer takes no new item until it has pushed the result of the last one,
// and the ring memory has a single write port.
// Reset clears pointers, fill, counters and both queues at once; ring contents are kept.
// Configuration resets to capture off and a snap length of 512.
`timescale 1ns / 1ps
`include "frame_capture_record_ring_defines.svh"

module frame_capture_record_ring #(
	parameter int RING_BYTES = fcrr_pkg::RING_BYTES_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fcrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcrr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	output logic                            full,
	input  fcrr_pkg::in_item_t              item,
	output logic                            empty,
	input  logic                            pop,
	output fcrr_pkg::result_t               result
);

	fcrr_pkg::cmd_t    cmd_din;
	fcrr_pkg::cmd_t    cmd_dout;
	logic              cmd_push;
	logic              cmd_full;
	logic              cmd_pop;
	logic              cmd_empty;
	fcrr_pkg::result_t res_din;
	logic              res_push;
	logic              res_full;

	fcrr_front #(
		.RING_BYTES(RING_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_push  (cmd_push),
		.cmd_full  (cmd_full),
		.cmd       (cmd_din)
	);

	fcrr_fifo #(
		.item_t (fcrr_pkg::cmd_t),
		.DEPTH  (fcrr_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.full   (cmd_full),
		.din    (cmd_din),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.dout   (cmd_dout)
	);

	fcrr_back #(
		.RING_BYTES(RING_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_dout),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res_din),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	fcrr_fifo #(
		.item_t (fcrr_pkg::result_t),
		.DEPTH  (fcrr_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.din    (res_din),
		.pop    (pop),
		.empty  (empty),
		.dout   (result)
	);

	`FCRR_ASSERT_NOW(a_res_no_overflow, clk, arst_n, res_push, !res_full, "result pushed into full queue")
	`FCRR_ASSERT_NOW(a_cmd_no_overflow, clk, arst_n, cmd_push, !cmd_full, "command pushed into full queue")
	`FCRR_ASSERT_NEXT(a_item_queued, clk, arst_n, push && !full, !cmd_empty, "accepted item not queued")

endmodule

### verif/frame_capture_record_ring_tb.sv
`timescale 1ns / 1ps

module frame_capture_record_ring_tb;
	import fcrr_pkg::*;

	localparam int RING_SIZE      = RING_BYTES_DEFAULT;
	localparam int unsigned MS_SEC  = MS_PER_SEC;
	localparam int unsigned USEC_MS = USEC_PER_MS;
	localparam logic [1:0] ACT_IDLE = 2'd3;
	localparam logic [1:0] FT_CTRL  = 2'd1;
	localparam logic [1:0] FT_OTHER = 2'd3;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 500;
	localparam int MAX_REPORTS    = 10;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  push      = 1'b0;
	logic                  full;
	in_item_t              item      = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	result_t               result;

	frame_capture_record_ring dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow copy of the capture ring and its counters
	logic [7:0]  ring_copy [RING_SIZE];
	logic [12:0] wr_ptr;
	logic [12:0] rd_ptr;
	logic [11:0] pend_bytes;
	logic [31:0] seen_cnt;
	logic [31:0] drop_cnt;
	logic        en_copy;
	logic [11:0] snap_copy;

	in_item_t queued_items[$];
	result_t  predicted_status[$];

	int  in_gap       = 0;
	int  out_gap      = 0;
	int  hold_left    = 0;
	int  results_seen = 0;
	int  fails        = 0;
	int  idle_cycles  = 0;
	bit  in_calm      = 1'b0;
	bit  out_calm     = 1'b0;

	function automatic logic [12:0] ring_fill();
		return wr_ptr - rd_ptr;
	endfunction

	task automatic ring_put(input logic [7:0] b);
		ring_copy[wr_ptr] = b;
		wr_ptr = wr_ptr + 13'd1;
	endtask

	task automatic ring_put_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			ring_put(w[8*k +: 8]);
	endtask

	task automatic capture_step(input in_item_t it, output result_t r);
		logic [11:0] incl;
		int          need;
		int          room;
		int unsigned tms;
		r = '0;
		case (it.action)
			ACT_FRAME_START: begin
				pend_bytes = '0;
				if (en_copy && (it.frame_type == FT_MGMT || it.frame_type == FT_DATA)) begin
					incl = (it.frame_length < snap_copy) ? it.frame_length : snap_copy;
					need = HDR_BYTES + int'(incl);
					room = RING_SIZE - 1 - int'(ring_fill());
					seen_cnt = seen_cnt + 32'd1;
					if (need > room) begin
						drop_cnt = drop_cnt + 32'd1;
					end else begin
						tms = it.time_ms;
						ring_put_word(tms / MS_SEC);
						ring_put_word((tms % MS_SEC) * USEC_MS);
						ring_put_word({20'd0, incl});
						ring_put_word({20'd0, it.frame_length});
						pend_bytes = incl;
						r.frame_accepted = 1'b1;
					end
				end
			end
			ACT_FRAME_DATA: begin
				if (pend_bytes != 0) begin
					ring_put(it.data_byte);
					pend_bytes = pend_bytes - 12'd1;
				end
			end
			ACT_READ: begin
				if (ring_fill() != 0) begin
					r.read_data  = ring_copy[rd_ptr];
					r.read_valid = 1'b1;
					rd_ptr = rd_ptr + 13'd1;
				end
			end
			default: ;
		endcase
		r.fill_bytes     = ring_fill();
		r.packets_seen   = seen_cnt;
		r.frames_dropped = drop_cnt;
	endtask

	task automatic check_status(input result_t want, input result_t got);
		logic bad;
		bad = (got.read_data !== want.read_data) || (got.read_valid !== want.read_valid)
			|| (got.frame_accepted !== want.frame_accepted)
			|| (got.fill_bytes !== want.fill_bytes)
			|| (got.packets_seen !== want.packets_seen)
			|| (got.frames_dropped !== want.frames_dropped);
		if (bad) begin
			fails++;
			if (fails <= MAX_REPORTS) begin
				$display("status %0d expected: data %h valid %b acc %b fill %0d seen %0d drop %0d",
					results_seen, want.read_data, want.read_valid, want.frame_accepted,
					want.fill_bytes, want.packets_seen, want.frames_dropped);
				$display("status %0d actual:   data %h valid %b acc %b fill %0d seen %0d drop %0d",
					results_seen, got.read_data, got.read_valid, got.frame_accepted,
					got.fill_bytes, got.packets_seen, got.frames_dropped);
			end
		end
	endtask

	function automatic int pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Sample handshakes, run the shadow ring, compare status
	always @(posedge clk) begin : sample
		result_t want;
		logic    moved;
		if (arst_n) begin
			moved = 1'b0;
			if (push && !full) begin
				capture_step(item, want);
				predicted_status.push_back(want);
				queued_items.delete(0);
				in_gap = pick_gap(in_calm);
				moved = 1'b1;
			end
			if (pop && !empty) begin
				results_seen++;
				if (predicted_status.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("status %0d arrived with nothing predicted", results_seen);
				end else begin
					want = predicted_status.pop_front();
					check_status(want, result);
				end
				out_gap = pick_gap(out_calm);
				// stall the output long enough to back the block up
				if (results_seen == 600 || results_seen == 1300)
					hold_left = HOLD_CYCLES;
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready)
				moved = 1'b1;
			if (moved) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("frame_capture_record_ring_tb: done, errors");
					$finish;
				end
			end
		end
	end

	always @(negedge clk) begin : feed
		if (in_gap > 0) begin
			push <= 1'b0;
			in_gap--;
		end else if (queued_items.size() != 0) begin
			push <= 1'b1;
			item <= queued_items[0];
		end else begin
			push <= 1'b0;
		end
	end

	always @(negedge clk) begin : drain
		if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left--;
		end else if (out_gap > 0) begin
			pop <= 1'b0;
			out_gap--;
		end else begin
			pop <= 1'b1;
		end
	end

	function automatic in_item_t random_item(logic [1:0] act);
		in_item_t    it;
		logic [31:0] r1;
		r1 = $urandom;
		it.action       = act;
		it.frame_type   = r1[1:0];
		it.frame_length = r1[13:2];
		it.data_byte    = r1[21:14];
		it.time_ms      = $urandom;
		return it;
	endfunction

	task automatic add_frame(input logic [1:0] ft, input logic [11:0] len,
			input logic [31:0] tms);
		in_item_t it;
		it = random_item(ACT_FRAME_START);
		it.frame_type   = ft;
		it.frame_length = len;
		it.time_ms      = tms;
		queued_items.push_back(it);
	endtask

	task automatic add_data(input logic [7:0] db);
		in_item_t it;
		it = random_item(ACT_FRAME_DATA);
		it.data_byte = db;
		queued_items.push_back(it);
	endtask

	task automatic add_reads(input int n);
		repeat (n) queued_items.push_back(random_item(ACT_READ));
	endtask

	task automatic settle();
		while (queued_items.size() != 0 || predicted_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_CAPTURE_EN)
			en_copy = val[0];
		else
			snap_copy = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_capture(input logic en);
		logic [31:0] r;
		r = $urandom;
		write_reg(CFG_CAPTURE_EN, {r[10:0], en});
	endtask

	// Mostly well-formed frames with their data bytes, read bursts in between
	task automatic random_traffic(input int n_items, input int max_len);
		int          n;
		int          nb;
		int          pick;
		int          len;
		in_item_t    it;
		logic [31:0] r;
		n = 0;
		while (n < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				it = random_item(ACT_FRAME_START);
				r = $urandom;
				if (r[3:0] < 4'd13)
					it.frame_type = r[4] ? FT_DATA : FT_MGMT;
				else
					it.frame_type = r[4] ? FT_OTHER : FT_CTRL;
				if (r[8:5] != 0)
					it.frame_length = 12'($urandom_range(0, max_len));
				len = int'(it.frame_length);
				nb = (len < 24) ? len : 24;
				if (r[11:9] == 0)
					nb = nb + $urandom_range(1, 3);
				else if (r[11:9] == 1)
					nb = $urandom_range(0, nb);
				queued_items.push_back(it);
				repeat (nb) queued_items.push_back(random_item(ACT_FRAME_DATA));
				n += 1 + nb;
			end else if (pick < 85) begin
				nb = $urandom_range(1, 30);
				add_reads(nb);
				n += nb;
			end else if (pick < 93) begin
				queued_items.push_back(random_item(ACT_FRAME_DATA));
			end else begin
				queued_items.push_back(random_item(ACT_IDLE));
			end
		end
	endtask

	task automatic run_phase(input logic en, input logic [11:0] snap, input int n_items,
			input int max_len);
		settle();
		set_capture(en);
		write_reg(CFG_SNAP_LEN, snap);
		in_calm  = ($urandom_range(0, 3) == 0);
		out_calm = ($urandom_range(0, 3) == 0);
		random_traffic(n_items, max_len);
	endtask

	initial begin : stimulus
		int          room;
		int          gap;
		in_item_t    ones;
		logic [31:0] r;

		wr_ptr     = '0;
		rd_ptr     = '0;
		pend_bytes = '0;
		seen_cnt   = '0;
		drop_cnt   = '0;
		en_copy    = 1'b0;
		snap_copy  = SNAP_LEN_RESET;
		ones       = '1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// capture off: frames ignored, empty read, stray byte
		add_frame(FT_MGMT, 12'd20, 32'd5);
		add_data(8'h11);
		add_reads(1);
		queued_items.push_back(random_item(ACT_IDLE));
		add_frame(FT_DATA, 12'd7, 32'd6);
		settle();
		set_capture(1'b1);

		// header only, then truncation at the reset snap length
		add_frame(FT_MGMT, 12'd0, 32'd0);
		add_data(8'hFF);
		add_frame(FT_DATA, 12'hFFF, 32'hFFFF_FFFF);
		add_data(8'h00);
		add_data(8'hFF);
		add_data(8'hA5);
		// control and other types abandon pending bytes
		add_frame(FT_CTRL, 12'd10, 32'd1);
		add_data(8'h5A);
		add_frame(FT_OTHER, 12'd10, 32'd2);
		add_frame(FT_MGMT, 12'd3, 32'd999);
		add_data(8'h01);
		add_data(8'h02);
		add_data(8'h03);
		add_data(8'h04);
		add_frame(FT_DATA, 12'd2, 32'd1000);
		add_data(8'h80);
		add_frame(FT_MGMT, 12'd1, 32'd1001);
		add_reads(8);
		queued_items.push_back(ones);

		// header-only records, then fill the ring until frames drop
		settle();
		write_reg(CFG_SNAP_LEN, 12'd0);
		add_frame(FT_MGMT, 12'd100, $urandom);
		add_data(8'h3C);
		add_reads(6);
		repeat (540) begin
			r = $urandom;
			add_frame(r[0] ? FT_MGMT : FT_DATA, r[12:1], $urandom);
			if (r[15:13] == 0)
				add_reads(1);
		end

		settle();
		write_reg(CFG_SNAP_LEN, 12'd1);
		add_frame(FT_DATA, 12'hFFF, $urandom);
		add_data(8'hC3);
		add_data(8'h3C);

		// fit a record to the exact free space, then run the ring full
		settle();
		write_reg(CFG_SNAP_LEN, 12'hFFF);
		room = RING_SIZE - 1 - int'(ring_fill());
		while (room > 200) begin
			repeat (16) add_frame(FT_MGMT, 12'd0, $urandom);
			settle();
			room = RING_SIZE - 1 - int'(ring_fill());
		end
		if (room < HDR_BYTES) begin
			add_reads(HDR_BYTES - room + $urandom_range(0, 5));
			settle();
			room = RING_SIZE - 1 - int'(ring_fill());
		end
		gap = room - HDR_BYTES;
		add_frame(FT_DATA, 12'(gap + 1), $urandom);
		add_frame(FT_MGMT, 12'(gap), $urandom);
		repeat (gap + 2) queued_items.push_back(random_item(ACT_FRAME_DATA));
		add_frame(FT_DATA, 12'd0, $urandom);
		add_reads(1);
		add_frame(FT_MGMT, 12'd0, $urandom);

		run_phase(1'b0, 12'($urandom_range(0, 4095)), 200, 30);
		run_phase(1'b1, 12'hFFF, 200, 40);
		run_phase(1'b1, 12'd1, 200, 30);
		run_phase(1'b1, 12'($urandom_range(2, 4094)), 200, 30);
		run_phase(1'b1, SNAP_LEN_RESET, 200, 30);

		settle();
		if (fails == 0 && predicted_status.size() == 0) begin
			$display("frame_capture_record_ring_tb: done, clean");
		end else begin
			$display("frame_capture_record_ring_tb: done, errors");
		end
		$finish;
	end

endmodule
